// ----- rtl/cdq_pkg.sv -----
package cdq_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int CAP_W       = 11;
    localparam int EXT_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int FUNC_W      = 3;
    localparam int VALUE_W     = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(MAX_ENTRIES);

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH_FRONT = 3'd0,
        FN_PUSH_BACK  = 3'd1,
        FN_POP_FRONT  = 3'd2,
        FN_POP_BACK   = 3'd3,
        FN_PEEK       = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic load;   // capture request beat
        logic exec;   // apply operation, write slot
        logic rd;     // read front and rear slots
    } cmd_t;

endpackage

// ----- rtl/cdq_if.sv -----
interface cdq_req_if import cdq_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [FUNC_W-1:0]         func;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

interface cdq_rsp_if import cdq_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      accepted;
    logic signed [VALUE_W-1:0] front_value;
    logic signed [VALUE_W-1:0] rear_value;
    logic                      is_empty;
    logic                      is_full;

    modport source (output valid, output accepted, output front_value, output rear_value,
                    output is_empty, output is_full, input ready);
    modport sink   (input valid, input accepted, input front_value, input rear_value,
                    input is_empty, input is_full, output ready);
endinterface

interface cdq_cfg_if import cdq_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] capacity;

    modport source (output valid, output capacity, input ready);
    modport sink   (input valid, input capacity, output ready);
endinterface

// ----- rtl/cdq_ctrl.sv -----
module cdq_ctrl import cdq_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic rsp_ready,
    output logic req_ready,
    output logic rsp_valid,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: state_next = ST_READ;
            ST_READ: state_next = ST_RESP;
            ST_RESP:
            begin
                if (rsp_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        req_ready = 1'b0;
        rsp_valid = 1'b0;
        cmd       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                cmd.load  = req_valid;
            end
            ST_EXEC: cmd.exec  = 1'b1;
            ST_READ: cmd.rd    = 1'b1;
            ST_RESP: rsp_valid = 1'b1;
            default: ;
        endcase
    end

endmodule

// ----- rtl/cdq_dpath.sv -----
module cdq_dpath import cdq_pkg::*; (
    input  logic                      clk,
    input  logic                      rst_n,
    input  cmd_t                      cmd,
    input  logic [FUNC_W-1:0]         in_func,
    input  logic signed [VALUE_W-1:0] in_value,
    input  logic                      cfg_we,
    input  logic [CAP_W-1:0]          cfg_capacity,
    output logic                      accepted,
    output logic signed [VALUE_W-1:0] front_value,
    output logic signed [VALUE_W-1:0] rear_value,
    output logic                      is_empty,
    output logic                      is_full
);

    logic [VALUE_W-1:0] mem [MAX_ENTRIES];

    logic [CAP_W-1:0]   capacity_reg;
    logic [IDX_W-1:0]   front_reg;
    logic [IDX_W-1:0]   front_next;
    logic [IDX_W-1:0]   rear_reg;
    logic [IDX_W-1:0]   rear_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [FUNC_W-1:0]  func_reg;
    logic [VALUE_W-1:0] value_reg;
    logic               acc_reg;
    logic               acc_next;
    logic [VALUE_W-1:0] rd_front_reg;
    logic [VALUE_W-1:0] rd_rear_reg;

    logic [EXT_W-1:0]   cap_ext;
    logic [EXT_W-1:0]   cap_eff;
    logic [IDX_W-1:0]   cap_m1;
    logic               empty_now;
    logic               full_now;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;

    // out-of-range capacity clamps to 1..MAX_ENTRIES
    always_comb
    begin
        cap_ext = EXT_W'(capacity_reg);
        if (capacity_reg == '0)
        begin
            cap_eff = EXT_W'(1);
        end
        else if (cap_ext > EXT_W'(MAX_ENTRIES))
        begin
            cap_eff = EXT_W'(MAX_ENTRIES);
        end
        else
        begin
            cap_eff = cap_ext;
        end
        cap_m1 = IDX_W'(cap_eff - EXT_W'(1));
    end

    assign empty_now = (count_reg == '0);
    assign full_now  = (EXT_W'(count_reg) >= cap_eff);

    // >= so a stale index past a shrunk capacity still wraps
    function automatic logic [IDX_W-1:0] idx_up(input logic [IDX_W-1:0] i,
                                                input logic [IDX_W-1:0] top);
        return (i >= top) ? '0 : i + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] idx_down(input logic [IDX_W-1:0] i,
                                                  input logic [IDX_W-1:0] top);
        return (i == '0) ? top : i - IDX_W'(1);
    endfunction

    always_comb
    begin
        front_next = front_reg;
        rear_next  = rear_reg;
        count_next = count_reg;
        acc_next   = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = '0;
        case (func_reg) inside
            FN_PUSH_FRONT, FN_PUSH_BACK:
            begin
                if (!full_now)
                begin
                    if (empty_now)
                    begin
                        front_next = '0;
                        rear_next  = '0;
                        wr_addr    = '0;
                    end
                    else if (func_reg == FN_PUSH_FRONT)
                    begin
                        front_next = idx_down(front_reg, cap_m1);
                        wr_addr    = front_next;
                    end
                    else
                    begin
                        rear_next = idx_up(rear_reg, cap_m1);
                        wr_addr   = rear_next;
                    end
                    wr_en      = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    acc_next   = 1'b1;
                end
            end
            FN_POP_FRONT:
            begin
                if (!empty_now)
                begin
                    front_next = idx_up(front_reg, cap_m1);
                    count_next = count_reg - CNT_W'(1);
                    acc_next   = 1'b1;
                end
            end
            FN_POP_BACK:
            begin
                if (!empty_now)
                begin
                    rear_next  = idx_down(rear_reg, cap_m1);
                    count_next = count_reg - CNT_W'(1);
                    acc_next   = 1'b1;
                end
            end
            FN_PEEK: acc_next = 1'b1;
            default: acc_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
            front_reg    <= '0;
            rear_reg     <= '0;
            count_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                capacity_reg <= cfg_capacity;
            end
            if (cmd.exec)
            begin
                front_reg <= front_next;
                rear_reg  <= rear_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg  <= in_func;
            value_reg <= in_value;
        end
        if (cmd.exec)
        begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && wr_en)
        begin
            mem[wr_addr] <= value_reg;
        end
        if (cmd.rd)
        begin
            rd_front_reg <= mem[front_reg];
            rd_rear_reg  <= mem[rear_reg];
        end
    end

    assign accepted    = acc_reg;
    assign is_empty    = empty_now;
    assign is_full     = full_now;
    assign front_value = empty_now ? '1 : rd_front_reg;
    assign rear_value  = empty_now ? '1 : rd_rear_reg;

endmodule

// ----- rtl/circular_double_ended_queue.sv -----
// Ring-buffer deque, one operation per request beat, one response beat each.
// Each request beat is captured in IDLE, then EXEC updates the indices and
// writes the slot, READ registers the front and rear slot reads, and RESP
// holds the response beat valid; the next request is taken the cycle after
// the response beat, so no new operation is taken until then.
// Reset: empty deque, both indices 0, capacity at full depth; slot contents
// are undefined until written.
module circular_double_ended_queue import cdq_pkg::*; (
    input logic      clk,
    input logic      rst_n,
    cdq_req_if.sink  req,
    cdq_rsp_if.source rsp,
    cdq_cfg_if.sink  cfg
);

    cmd_t cmd;

    assign cfg.ready = 1'b1;

    cdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .rsp_ready (rsp.ready),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .cmd       (cmd)
    );

    cdq_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .in_func      (req.func),
        .in_value     (req.value),
        .cfg_we       (cfg.valid),
        .cfg_capacity (cfg.capacity),
        .accepted     (rsp.accepted),
        .front_value  (rsp.front_value),
        .rear_value   (rsp.rear_value),
        .is_empty     (rsp.is_empty),
        .is_full      (rsp.is_full)
    );

endmodule

// ----- rtl/cdq_checker.sv -----
module cdq_checker import cdq_pkg::*; (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_ready,
    input logic [FUNC_W-1:0]  req_func,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input logic               rsp_accepted,
    input logic [VALUE_W-1:0] rsp_front_value,
    input logic [VALUE_W-1:0] rsp_rear_value,
    input logic               rsp_is_empty,
    input logic               rsp_is_full
);

    logic [FUNC_W-1:0] last_func_reg;
    logic [FUNC_W-1:0] last_func_next;

    assign last_func_next = (req_valid && req_ready) ? req_func : last_func_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_func_reg <= '0;
        end
        else
        begin
            last_func_reg <= last_func_next;
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_front_value)
            && $stable(rsp_rear_value) && $stable(rsp_accepted))
        else $error("response beat changed while stalled");

    a_empty_marks: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_is_empty |-> rsp_front_value == '1 && rsp_rear_value == '1)
        else $error("empty deque must report -1 at both ends");

    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp_is_empty && rsp_is_full))
        else $error("empty and full at once");

    a_peek_acc: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && last_func_reg == FN_PEEK |-> rsp_accepted)
        else $error("peek not accepted");

    a_bad_func: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && last_func_reg > FN_PEEK |-> !rsp_accepted)
        else $error("unknown operation accepted");

endmodule

bind circular_double_ended_queue cdq_checker u_cdq_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .req_func        (req.func),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_accepted    (rsp.accepted),
    .rsp_front_value (rsp.front_value),
    .rsp_rear_value  (rsp.rear_value),
    .rsp_is_empty    (rsp.is_empty),
    .rsp_is_full     (rsp.is_full)
);
